FILE: sv/proportional_count_distributor_defines.svh
// ----------------------------------------------------------------------------
// Proportional count distributor: assertion macros
// Shared macros that write the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef PROPORTIONAL_COUNT_DISTRIBUTOR_DEFINES_SVH
`define PROPORTIONAL_COUNT_DISTRIBUTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PCD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/pcd_pkg.sv
// ----------------------------------------------------------------------------
// Proportional count distributor package
// Field widths and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam int WEIGHT_W  = 16;
   localparam int TOTAL_W   = 16;
   localparam int SUM_W     = 22;
   localparam int PROD_W    = TOTAL_W + SUM_W;
   localparam int INDEX_W   = 6;
   localparam int DIV_STEPS = TOTAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // a weight beat is accepted
      logic start;     // the accepted beat was the last one
      logic rd;        // read the weight of the current frame
      logic acc;       // add the read weight to the prefix sum
      logic mul;       // form total times prefix and load the divider
      logic div_step;  // one quotient bit
      logic emit;      // write the result of the current frame
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic zero;        // weight sum of the batch is zero
      logic div_last;    // this divider step is the final one
      logic frame_last;  // current frame is the last loaded one
      logic out_free;    // the result register can take a new value
   } sts_type;

endpackage

FILE: sv/pcd_req_if.sv
// ----------------------------------------------------------------------------
// Weight request channel
// Valid/ready channel that carries one frame weight per beat.
// ----------------------------------------------------------------------------
interface pcd_req_if;

   logic                           valid;
   logic                           ready;
   logic [pcd_pkg::WEIGHT_W-1:0]   weight;
   logic                           last_weight;

   modport source (output valid, output weight, output last_weight, input ready);
   modport sink (input valid, input weight, input last_weight, output ready);

endinterface

FILE: sv/pcd_rsp_if.sv
// ----------------------------------------------------------------------------
// Frame count response channel
// Valid/ready channel that carries the count of one frame per beat.
// ----------------------------------------------------------------------------
interface pcd_rsp_if;

   logic                           valid;
   logic                           ready;
   logic [pcd_pkg::INDEX_W-1:0]    frame_index;
   logic [pcd_pkg::TOTAL_W-1:0]    frame_count;
   logic                           zero_sum;
   logic                           last_count;

   modport source (output valid, output frame_index, output frame_count,
                   output zero_sum, output last_count, input ready);
   modport sink (input valid, input frame_index, input frame_count,
                 input zero_sum, input last_count, output ready);

endinterface

FILE: sv/pcd_ctrl.sv
// ----------------------------------------------------------------------------
// Proportional count distributor controller
// Sequences loading and the per-frame read, prefix add, multiply, divide and emit steps.
// ----------------------------------------------------------------------------
module pcd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  pcd_pkg::sts_type sts,
   output pcd_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No beat is taken while reset is high.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.zero ? ST_OUT : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.frame_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/pcd_datapath.sv
// ----------------------------------------------------------------------------
// Proportional count distributor datapath
// Weight store, running sum, prefix multiply, radix-2 divider and result
// register.
// ----------------------------------------------------------------------------
module pcd_datapath #(
   parameter int MAX_FRAMES = 64,
   parameter int AW         = 6,
   parameter int CW         = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcd_pkg::cmd_type              cmd,
   output pcd_pkg::sts_type              sts,
   input  logic [pcd_pkg::WEIGHT_W-1:0]  req_weight,
   input  logic                          csr_we,
   input  logic [pcd_pkg::TOTAL_W-1:0]   csr_wdata,
   pcd_rsp_if.source                     rsp
);

   logic [pcd_pkg::WEIGHT_W-1:0]  mem [MAX_FRAMES];
   logic [pcd_pkg::WEIGHT_W-1:0]  rd_data_ff;

   logic [pcd_pkg::TOTAL_W-1:0]   total_ff;
   logic [pcd_pkg::SUM_W-1:0]     sum_ff;
   logic [CW-1:0]                 loaded_ff;
   logic [AW-1:0]                 idx_ff;
   logic [pcd_pkg::SUM_W-1:0]     prefix_ff;
   logic [pcd_pkg::TOTAL_W-1:0]   prev_ff;
   logic [pcd_pkg::SUM_W-1:0]     rem_ff;
   logic [pcd_pkg::TOTAL_W-1:0]   quo_ff;
   logic [pcd_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   logic                          rsp_valid_ff;
   logic [pcd_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic [pcd_pkg::TOTAL_W-1:0]   rsp_count_ff;
   logic                          rsp_zero_ff;
   logic                          rsp_last_ff;

   logic                          full;
   logic [pcd_pkg::PROD_W-1:0]    prod;
   logic [pcd_pkg::SUM_W+1:0]     trial;
   logic [pcd_pkg::TOTAL_W-1:0]   count;

   assign full = (loaded_ff == CW'(MAX_FRAMES));

   // The product is below 2^16 times the sum, so its upper part already
   // holds a partial remainder smaller than the divisor: 16 steps suffice.
   assign prod  = pcd_pkg::PROD_W'(total_ff) * pcd_pkg::PROD_W'(prefix_ff);
   assign trial = {1'b0, rem_ff, quo_ff[pcd_pkg::TOTAL_W-1]} - {2'b00, sum_ff};
   assign count = sts.zero ? '0 : (quo_ff - prev_ff);

   assign sts.zero       = (sum_ff == '0);
   assign sts.div_last   = (div_cnt_ff == pcd_pkg::DIV_CNT_W'(pcd_pkg::DIV_STEPS - 1));
   assign sts.frame_last = ((CW'(idx_ff) + CW'(1)) == loaded_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp.ready;

   // Weight store: one write port on load, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[loaded_ff[AW-1:0]] <= req_weight;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         sum_ff       <= '0;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
         if (cmd.emit && sts.frame_last) begin
            sum_ff    <= '0;
            loaded_ff <= '0;
         end else if (cmd.load && !full) begin
            sum_ff    <= sum_ff + pcd_pkg::SUM_W'(req_weight);
            loaded_ff <= loaded_ff + CW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff    <= '0;
         prefix_ff <= '0;
         prev_ff   <= '0;
      end
      if (cmd.acc) begin
         prefix_ff <= prefix_ff + pcd_pkg::SUM_W'(rd_data_ff);
      end
      if (cmd.mul) begin
         rem_ff     <= prod[pcd_pkg::PROD_W-1:pcd_pkg::TOTAL_W];
         quo_ff     <= prod[pcd_pkg::TOTAL_W-1:0];
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + pcd_pkg::DIV_CNT_W'(1);
         if (trial[pcd_pkg::SUM_W+1]) begin
            rem_ff <= {rem_ff[pcd_pkg::SUM_W-2:0], quo_ff[pcd_pkg::TOTAL_W-1]};
            quo_ff <= {quo_ff[pcd_pkg::TOTAL_W-2:0], 1'b0};
         end else begin
            rem_ff <= trial[pcd_pkg::SUM_W-1:0];
            quo_ff <= {quo_ff[pcd_pkg::TOTAL_W-2:0], 1'b1};
         end
      end
      if (cmd.emit) begin
         rsp_index_ff <= pcd_pkg::INDEX_W'(idx_ff);
         rsp_count_ff <= count;
         rsp_zero_ff  <= sts.zero;
         rsp_last_ff  <= sts.frame_last;
         prev_ff      <= quo_ff;
         idx_ff       <= idx_ff + AW'(1);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.frame_index = rsp_index_ff;
   assign rsp.frame_count = rsp_count_ff;
   assign rsp.zero_sum    = rsp_zero_ff;
   assign rsp.last_count  = rsp_last_ff;

endmodule

FILE: sv/proportional_count_distributor.sv
// ----------------------------------------------------------------------------
// Proportional count distributor
// Loads frame weights and hands a configured total out over the frames in
// proportion to their weights, with the remainder carried forward exactly.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   req_bus   in         valid/ready    weight, last_weight
//   rsp_bus   out        valid/ready    frame_index, frame_count, zero_sum,
//                                       last_count
//   csr       in         write enable   total_count
//
// Weight beats are taken at one per cycle; ready is low during reset and from
// the last beat until the final count sits in the result register.
// Each frame of the pass runs read, prefix add, multiply, 16 radix-2 divider steps
// and emit in that order; with a zero weight sum it runs read, prefix add and emit.
// Reset is synchronous and clears the batch and the total count register.
// A stalled result holds the pass at emit; the last one may wait while a batch loads.
// ----------------------------------------------------------------------------
`include "proportional_count_distributor_defines.svh"

module proportional_count_distributor #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   pcd_req_if.sink                      req_bus,
   pcd_rsp_if.source                    rsp_bus,
   input  logic                         csr_we,
   input  logic [pcd_pkg::TOTAL_W-1:0]  csr_wdata
);

   // Store address width and frame count width; a single-frame store still
   // keeps one address bit.
   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW = $clog2(MAX_FRAMES + 1);

   pcd_pkg::cmd_type cmd;
   pcd_pkg::sts_type sts;

   // The controller owns the handshake on the weight side and the order of
   // the per-frame steps; all arithmetic and storage sits in the datapath.
   pcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_weight),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath computes floor(total * prefix / sum) for each frame and
   // emits the difference to the previous floor, so counts add up exactly.
   pcd_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .AW         (AW),
      .CW         (CW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_weight (req_bus.weight),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp        (rsp_bus)
   );

   // No divider or emit activity while weights are being taken.
   `PCD_ASSERT_IMPL(a_idle_no_pass, clock, reset, req_bus.ready, !cmd.div_step && !cmd.emit, "pass step while loading")
   // A result is never written over one that still waits.
   `PCD_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, sts.out_free, "result overwritten")
   // A zero weight sum always yields zero counts.
   `PCD_ASSERT_IMPL(a_zero_count, clock, reset, rsp_bus.valid && rsp_bus.zero_sum, rsp_bus.frame_count == '0, "nonzero count on zero sum")
   // The last weight beat closes the input until the pass is done.
   `PCD_ASSERT_NEXT(a_start_blocks, clock, reset, cmd.start, !req_bus.ready, "ready after last beat")

endmodule
